// ----- rtl/lfusr_pkg.sv -----
// Shared widths, limits and the scan status type of the LFU slot table.
package lfusr_pkg;

    localparam int COUNT_BITS = 16;
    localparam int STAMP_BITS = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    typedef struct packed {
        logic hit_found;
        logic victim_found;
        logic free_found;
    } scan_flags_t;

endpackage

// ----- rtl/lfusr_mem.sv -----
// Slot entry memory: one write port and one read port with registered read data.
module lfusr_mem #(
    parameter int DEPTH     = 16,
    parameter int WIDTH     = 56,
    parameter int ADDR_BITS = 4
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/lfusr_scan.sv -----
// Scan accumulator: finds the matching slot, the eviction victim, the first free slot
// and the occupancy while the entries stream out of the memory one per cycle.
module lfusr_scan #(
    parameter int KEY_BITS  = 8,
    parameter int SLOT_BITS = 4,
    parameter int OCC_BITS  = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               cmp_valid,
    input  logic                               cmp_slot_valid,
    input  logic [SLOT_BITS-1:0]               cmp_idx,
    input  logic [KEY_BITS-1:0]                cmp_key,
    input  logic [lfusr_pkg::COUNT_BITS-1:0]   cmp_count,
    input  logic [lfusr_pkg::STAMP_BITS-1:0]   cmp_stamp,
    input  logic [KEY_BITS-1:0]                key,
    output lfusr_pkg::scan_flags_t             flags,
    output logic [OCC_BITS-1:0]                occupied,
    output logic [SLOT_BITS-1:0]               hit_idx,
    output logic [lfusr_pkg::COUNT_BITS-1:0]   hit_count,
    output logic [lfusr_pkg::STAMP_BITS-1:0]   hit_stamp,
    output logic [SLOT_BITS-1:0]               victim_idx,
    output logic [KEY_BITS-1:0]                victim_key,
    output logic [SLOT_BITS-1:0]               free_idx
);

    lfusr_pkg::scan_flags_t flags_reg;
    logic [OCC_BITS-1:0]              occupied_reg;
    logic [SLOT_BITS-1:0]             hit_idx_reg;
    logic [lfusr_pkg::COUNT_BITS-1:0] hit_count_reg;
    logic [lfusr_pkg::STAMP_BITS-1:0] hit_stamp_reg;
    logic [SLOT_BITS-1:0]             victim_idx_reg;
    logic [KEY_BITS-1:0]              victim_key_reg;
    logic [lfusr_pkg::COUNT_BITS-1:0] victim_count_reg;
    logic [lfusr_pkg::STAMP_BITS-1:0] victim_stamp_reg;
    logic [SLOT_BITS-1:0]             free_idx_reg;

    logic take_hit;
    logic take_victim;
    logic take_free;
    logic cmp_before;

    // Eviction order: lowest count, then earliest stamp, then smallest key.
    assign cmp_before = {cmp_count, cmp_stamp, cmp_key}
                      < {victim_count_reg, victim_stamp_reg, victim_key_reg};

    assign take_hit    = cmp_valid && cmp_slot_valid && (cmp_key == key);
    assign take_victim = cmp_valid && cmp_slot_valid && (!flags_reg.victim_found || cmp_before);
    assign take_free   = cmp_valid && !cmp_slot_valid && !flags_reg.free_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            occupied_reg <= '0;
        end
        else if (start)
        begin
            flags_reg    <= '0;
            occupied_reg <= '0;
        end
        else
        begin
            if (cmp_valid && cmp_slot_valid)
            begin
                occupied_reg <= occupied_reg + OCC_BITS'(1);
            end
            if (take_hit)
            begin
                flags_reg.hit_found <= 1'b1;
            end
            if (take_victim)
            begin
                flags_reg.victim_found <= 1'b1;
            end
            if (take_free)
            begin
                flags_reg.free_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!start && take_hit)
        begin
            hit_idx_reg   <= cmp_idx;
            hit_count_reg <= cmp_count;
            hit_stamp_reg <= cmp_stamp;
        end
        if (!start && take_victim)
        begin
            victim_idx_reg   <= cmp_idx;
            victim_key_reg   <= cmp_key;
            victim_count_reg <= cmp_count;
            victim_stamp_reg <= cmp_stamp;
        end
        if (!start && take_free)
        begin
            free_idx_reg <= cmp_idx;
        end
    end

    assign flags      = flags_reg;
    assign occupied   = occupied_reg;
    assign hit_idx    = hit_idx_reg;
    assign hit_count  = hit_count_reg;
    assign hit_stamp  = hit_stamp_reg;
    assign victim_idx = victim_idx_reg;
    assign victim_key = victim_key_reg;
    assign free_idx   = free_idx_reg;

endmodule

// ----- rtl/lfu_slot_replacement_core.sv -----
// LFU slot replacement table with oldest-first tie-break: top level.
//
// Input items (key_in) arrive on a valid/ready channel and each produces exactly one
// result item on the output valid/ready channel: whether the key hit, the slot that
// now holds it, whether another key was evicted (and which), and its hit count.
// The configuration channel (cfg_valid/cfg_ready, data active_slots) is always ready
// and should be written only while the table is idle; 0 acts as 1 and values above
// SLOTS act as SLOTS.
// From acceptance to the next acceptance an item goes through the accept cycle, the scan
// that streams every entry of the memory through its single read port, the last
// comparison and the update that writes the entry back and loads the output register.
// The result is visible the cycle after the update. Items are handled one at a time, so
// the write-back always finishes before the next scan reads the memory.
// If the receiver stalls, the finished result waits in the output register while the
// next item is accepted and scanned; its update waits until that register is free.
// Reset clears all slot valid bits, the arrival stamp counter and the output valid;
// the entry memory itself is not cleared, unused entries are masked by the valid bits.
module lfu_slot_replacement_core #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 8
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  logic [KEY_BITS-1:0]                               key_in,
    input  logic                                              cfg_valid,
    output logic                                              cfg_ready,
    input  logic [$clog2(SLOTS+1)-1:0]                        active_slots,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic                                              was_hit,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]      slot_used,
    output logic                                              did_evict,
    output logic [KEY_BITS-1:0]                               evicted_key,
    output logic [lfusr_pkg::COUNT_BITS-1:0]                  count_after
);

    localparam int SLOT_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OCC_BITS   = $clog2(SLOTS+1);
    localparam int CNT_BITS   = lfusr_pkg::COUNT_BITS;
    localparam int STP_BITS   = lfusr_pkg::STAMP_BITS;
    localparam int ENTRY_BITS = KEY_BITS + CNT_BITS + STP_BITS;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_LAST   = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [SLOT_BITS-1:0]  scan_cnt_reg;
    logic [SLOTS-1:0]      valid_reg;
    logic [SLOTS-1:0]      valid_next;
    logic [OCC_BITS-1:0]   active_reg;
    logic [STP_BITS-1:0]   arrival_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [STP_BITS-1:0]   stamp_reg;
    logic                  cmp_valid_reg;
    logic                  cmp_slot_valid_reg;
    logic [SLOT_BITS-1:0]  cmp_idx_reg;

    logic                  out_valid_reg;
    logic                  was_hit_reg;
    logic [SLOT_BITS-1:0]  slot_used_reg;
    logic                  did_evict_reg;
    logic [KEY_BITS-1:0]   evicted_key_reg;
    logic [CNT_BITS-1:0]   count_after_reg;

    logic                  accept;
    logic                  scanning;
    logic                  commit;
    logic [ENTRY_BITS-1:0] rd_entry;
    logic [ENTRY_BITS-1:0] wr_entry;

    lfusr_pkg::scan_flags_t flags;
    logic [OCC_BITS-1:0]    occupied;
    logic [SLOT_BITS-1:0]   hit_idx;
    logic [CNT_BITS-1:0]    hit_count;
    logic [STP_BITS-1:0]    hit_stamp;
    logic [SLOT_BITS-1:0]   victim_idx;
    logic [KEY_BITS-1:0]    victim_key;
    logic [SLOT_BITS-1:0]   free_idx;

    logic [OCC_BITS-1:0]    limit;
    logic                   evict;
    logic [SLOT_BITS-1:0]   new_slot;
    logic [CNT_BITS-1:0]    new_count;
    logic [STP_BITS-1:0]    new_stamp;

    assign accept    = in_valid && in_ready;
    assign scanning  = (state_reg == ST_SCAN);
    assign commit    = (state_reg == ST_UPDATE) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    lfusr_mem #(
        .DEPTH     (SLOTS),
        .WIDTH     (ENTRY_BITS),
        .ADDR_BITS (SLOT_BITS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (commit),
        .wr_addr (new_slot),
        .wr_data (wr_entry),
        .rd_en   (scanning),
        .rd_addr (scan_cnt_reg),
        .rd_data (rd_entry)
    );

    lfusr_scan #(
        .KEY_BITS  (KEY_BITS),
        .SLOT_BITS (SLOT_BITS),
        .OCC_BITS  (OCC_BITS)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (accept),
        .cmp_valid      (cmp_valid_reg),
        .cmp_slot_valid (cmp_slot_valid_reg),
        .cmp_idx        (cmp_idx_reg),
        .cmp_key        (rd_entry[ENTRY_BITS-1 -: KEY_BITS]),
        .cmp_count      (rd_entry[STP_BITS +: CNT_BITS]),
        .cmp_stamp      (rd_entry[STP_BITS-1:0]),
        .key            (key_reg),
        .flags          (flags),
        .occupied       (occupied),
        .hit_idx        (hit_idx),
        .hit_count      (hit_count),
        .hit_stamp      (hit_stamp),
        .victim_idx     (victim_idx),
        .victim_key     (victim_key),
        .free_idx       (free_idx)
    );

    // Decision for the update cycle, from the finished scan.
    always_comb
    begin
        if (active_reg == '0)
        begin
            limit = OCC_BITS'(1);
        end
        else if (active_reg > OCC_BITS'(SLOTS))
        begin
            limit = OCC_BITS'(SLOTS);
        end
        else
        begin
            limit = active_reg;
        end

        evict = !flags.hit_found && flags.victim_found && (occupied >= limit);

        priority if (flags.hit_found)
        begin
            new_slot = hit_idx;
        end
        else if (evict && (!flags.free_found || (victim_idx < free_idx)))
        begin
            new_slot = victim_idx;
        end
        else if (flags.free_found)
        begin
            new_slot = free_idx;
        end
        else
        begin
            new_slot = '0;
        end

        valid_next = valid_reg;
        if (evict)
        begin
            valid_next[victim_idx] = 1'b0;
        end
        valid_next[new_slot] = 1'b1;

        if (flags.hit_found)
        begin
            new_count = (hit_count == lfusr_pkg::COUNT_MAX) ? hit_count
                                                            : hit_count + CNT_BITS'(1);
            new_stamp = hit_stamp;
        end
        else
        begin
            new_count = CNT_BITS'(1);
            new_stamp = stamp_reg;
        end

        wr_entry = {key_reg, new_count, new_stamp};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == SLOT_BITS'(SLOTS-1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            valid_reg     <= '0;
            active_reg    <= OCC_BITS'(SLOTS);
            arrival_reg   <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= scanning;

            if (cfg_valid && cfg_ready)
            begin
                active_reg <= active_slots;
            end

            if (accept)
            begin
                scan_cnt_reg <= '0;
                if (arrival_reg != lfusr_pkg::STAMP_MAX)
                begin
                    arrival_reg <= arrival_reg + STP_BITS'(1);
                end
            end
            else if (scanning)
            begin
                scan_cnt_reg <= scan_cnt_reg + SLOT_BITS'(1);
            end

            if (commit)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg   <= key_in;
            stamp_reg <= arrival_reg;
        end
        if (scanning)
        begin
            cmp_idx_reg        <= scan_cnt_reg;
            cmp_slot_valid_reg <= valid_reg[scan_cnt_reg];
        end
        if (commit)
        begin
            was_hit_reg     <= flags.hit_found;
            slot_used_reg   <= new_slot;
            did_evict_reg   <= evict;
            evicted_key_reg <= evict ? victim_key : '0;
            count_after_reg <= new_count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign was_hit     = was_hit_reg;
    assign slot_used   = slot_used_reg;
    assign did_evict   = did_evict_reg;
    assign evicted_key = evicted_key_reg;
    assign count_after = count_after_reg;

`ifndef SYNTHESIS
    a_out_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_UPDATE)
        else $error("result appeared without an update cycle");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(was_hit && did_evict) && (did_evict || evicted_key == '0))
        else $error("eviction reported on a hit or stray evicted key");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count_after != '0)
        else $error("result count is zero");

    a_idle_no_compare: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmp_valid_reg && !scanning)
        else $error("new item accepted while a scan is in flight");
`endif

endmodule
